FILE: rtl/core/rwas_pkg.sv
// ----------------------------------------------------------------------------
// rwas_pkg
// Shared types, codes and tables of the recurring wake alarm scheduler.
// ----------------------------------------------------------------------------
package rwas_pkg;

  // register index of the configuration port
  typedef enum logic [2:0] {
    CFG_TIMER_ENABLED  = 3'd0,
    CFG_FREQUENCY      = 3'd1,
    CFG_START_HOUR     = 3'd2,
    CFG_START_MINUTE   = 3'd3,
    CFG_STOP_HOUR      = 3'd4,
    CFG_START_DATE     = 3'd5,
    CFG_STOP_DATE      = 3'd6,
    CFG_ACTIVE_MINUTES = 3'd7
  } cfg_idx_e;

  // recurrence codes held in the frequency register
  localparam logic [2:0] FREQ_ONCE     = 3'd0;
  localparam logic [2:0] FREQ_DAILY    = 3'd1;
  localparam logic [2:0] FREQ_HOURLY   = 3'd2;
  localparam logic [2:0] FREQ_WEEKDAYS = 3'd3;
  localparam logic [2:0] FREQ_WEEKLY   = 3'd4;
  localparam logic [2:0] FREQ_MONTHLY  = 3'd5;

  // classification of a time stamp
  typedef enum logic [2:0] {
    DEC_EXPIRED     = 3'd0,
    DEC_NOT_STARTED = 3'd1,
    DEC_WEEKEND_OFF = 3'd2,
    DEC_MONTHLY_OFF = 3'd3,
    DEC_LAST_RUN    = 3'd4,
    DEC_RUN         = 3'd5
  } dec_e;

  // calendar constants
  localparam logic [2:0] WD_SUNDAY     = 3'd1;
  localparam logic [2:0] WD_FRIDAY     = 3'd6;
  localparam logic [2:0] WD_SATURDAY   = 3'd7;
  localparam logic [5:0] LAST_MINUTE   = 6'd59;
  localparam logic [5:0] LAST_HOUR     = 6'd23;
  localparam logic [3:0] LAST_MONTH    = 4'd12;
  localparam logic [5:0] DAYS_PER_WEEK = 6'd7;
  localparam logic [17:0] TICKS_PER_MIN = 18'd120;

  typedef struct packed {
    logic        timer_enabled;
    logic [2:0]  frequency;
    logic [4:0]  start_hour;
    logic [5:0]  start_minute;
    logic [4:0]  stop_hour;
    logic [15:0] start_date;
    logic [15:0] stop_date;
    logic [10:0] active_minutes;
  } rwas_cfg_t;

  // register values after reset, one minute of on time
  localparam rwas_cfg_t CFG_RESET = '{1'b0, FREQ_ONCE, 5'd0, 6'd0, 5'd0,
                                      16'd0, 16'd0, 11'd1};

  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] weekday;
  } rwas_item_t;

  typedef struct packed {
    logic        start_match;
    logic [2:0]  decision;
    logic        alarm_valid;
    logic [4:0]  alarm_day;
    logic [4:0]  alarm_hour;
    logic [5:0]  alarm_minute;
    logic [17:0] power_off_ticks;
  } rwas_result_t;

  // compare flags and partial sums handed from the front stage to the back stage
  typedef struct packed {
    logic        match;
    logic        gt_stop;
    logic        lt_start;
    logic        eq_stop;
    logic        weekend;
    logic        day_ne;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [4:0]  mlen;
    logic [4:0]  nlen;
    logic [5:0]  day_p1;
    logic [5:0]  day_wk;
    logic [5:0]  day_p7;
    logic [5:0]  hour_p1;
    logic [17:0] on_ticks;
    logic [6:0]  off_ticks;
  } rwas_front_t;

  // fixed month lengths, anything outside 1..12 counts as 31 days
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd2:                      len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/core/rwas_cfg.sv
// ----------------------------------------------------------------------------
// rwas_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module rwas_cfg import rwas_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  output rwas_cfg_t   cfg_o
);

  rwas_cfg_t cfg_q, cfg_d;
  cfg_idx_e  idx;

  assign idx = cfg_idx_e'(cfg_idx_i);

  // register decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (idx)
        CFG_TIMER_ENABLED:  cfg_d.timer_enabled  = cfg_wdata_i[0];
        CFG_FREQUENCY:      cfg_d.frequency      = cfg_wdata_i[2:0];
        CFG_START_HOUR:     cfg_d.start_hour     = cfg_wdata_i[4:0];
        CFG_START_MINUTE:   cfg_d.start_minute   = cfg_wdata_i[5:0];
        CFG_STOP_HOUR:      cfg_d.stop_hour      = cfg_wdata_i[4:0];
        CFG_START_DATE:     cfg_d.start_date     = cfg_wdata_i;
        CFG_STOP_DATE:      cfg_d.stop_date      = cfg_wdata_i;
        CFG_ACTIVE_MINUTES: cfg_d.active_minutes = cfg_wdata_i[10:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/rwas_front.sv
// ----------------------------------------------------------------------------
// rwas_front
// First compute stage: slot match, date compares, month lengths and day sums.
// ----------------------------------------------------------------------------
module rwas_front import rwas_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rwas_cfg_t   cfg_i,
  input  logic        valid_i,
  input  rwas_item_t  item_i,
  output logic        valid_o,
  output rwas_front_t front_o
);

  rwas_front_t front_d, front_q;
  logic        valid_q;
  logic [15:0] now;
  logic [6:0]  sm_inc;
  logic        window;
  logic        same_hour;
  logic [5:0]  wk_add;
  logic [3:0]  next_month;

  // packed date, year*512 + month*32 + day
  assign now = {item_i.year, item_i.month, item_i.day};
  assign sm_inc = {1'b0, cfg_i.start_minute} + 7'd1;
  assign same_hour = (cfg_i.start_hour == item_i.hour);

  // hourly window, wrap-around only when start is later than stop
  always_comb begin
    window = (cfg_i.start_hour == cfg_i.stop_hour) ||
             ((cfg_i.start_hour < cfg_i.stop_hour) && (item_i.hour >= cfg_i.start_hour) &&
              (item_i.hour <= cfg_i.stop_hour)) ||
             ((cfg_i.start_hour > cfg_i.stop_hour) && ((item_i.hour >= cfg_i.start_hour) ||
              (item_i.hour <= cfg_i.stop_hour)));
  end

  // days to the next weekday
  always_comb begin
    if (item_i.weekday == WD_FRIDAY) begin
      wk_add = 6'd3;
    end else if (item_i.weekday == WD_SATURDAY) begin
      wk_add = 6'd2;
    end else begin
      wk_add = 6'd1;
    end
  end

  assign next_month = (item_i.month >= 4'd1 && item_i.month < LAST_MONTH) ?
                      item_i.month + 4'd1 : 4'd1;

  // stage logic
  always_comb begin
    front_d.match = cfg_i.timer_enabled &&
                    ((same_hour && (cfg_i.start_minute == item_i.minute)) ||
                     (same_hour && (((cfg_i.start_minute == LAST_MINUTE) &&
                                     (item_i.minute == 6'd0)) ||
                                    (sm_inc == {1'b0, item_i.minute}))) ||
                     ((cfg_i.frequency == FREQ_HOURLY) &&
                      (cfg_i.start_minute == item_i.minute) && window));
    front_d.gt_stop   = (now > cfg_i.stop_date);
    front_d.lt_start  = (now < cfg_i.start_date);
    front_d.eq_stop   = (now == cfg_i.stop_date);
    front_d.weekend   = (item_i.weekday == WD_SATURDAY) || (item_i.weekday == WD_SUNDAY);
    front_d.day_ne    = (item_i.day != cfg_i.start_date[4:0]);
    front_d.day       = item_i.day;
    front_d.hour      = item_i.hour;
    front_d.mlen      = month_len(item_i.month);
    front_d.nlen      = month_len(next_month);
    front_d.day_p1    = {1'b0, item_i.day} + 6'd1;
    front_d.day_wk    = {1'b0, item_i.day} + wk_add;
    front_d.day_p7    = {1'b0, item_i.day} + DAYS_PER_WEEK;
    front_d.hour_p1   = {1'b0, item_i.hour} + 6'd1;
    front_d.on_ticks  = 18'(cfg_i.active_minutes) * TICKS_PER_MIN;
    front_d.off_ticks = {item_i.second, 1'b0};
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    front_q <= front_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  assign valid_o = valid_q;
  assign front_o = front_q;

endmodule

FILE: rtl/core/rwas_back.sv
// ----------------------------------------------------------------------------
// rwas_back
// Second compute stage: decision, next alarm and power-off tick count.
// ----------------------------------------------------------------------------
module rwas_back import rwas_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  rwas_cfg_t    cfg_i,
  input  logic         valid_i,
  input  rwas_front_t  front_i,
  output logic         valid_o,
  output rwas_result_t result_o
);

  rwas_result_t res_d, res_q;
  logic         valid_q;
  dec_e         dec;
  logic         freq_ok;
  logic [4:0]   daily_day;
  logic [4:0]   wk_day;
  logic [4:0]   weekly_day;
  logic [4:0]   monthly_day;
  logic [4:0]   hr_day;
  logic [4:0]   hr_hour;

  // classification, first matching rule wins
  always_comb begin
    if (front_i.gt_stop) begin
      dec = DEC_EXPIRED;
    end else if (front_i.lt_start) begin
      dec = DEC_NOT_STARTED;
    end else if ((cfg_i.frequency == FREQ_WEEKDAYS) && front_i.weekend) begin
      dec = DEC_WEEKEND_OFF;
    end else if ((cfg_i.frequency == FREQ_MONTHLY) && front_i.day_ne) begin
      dec = DEC_MONTHLY_OFF;
    end else if ((cfg_i.frequency != FREQ_HOURLY) && front_i.eq_stop) begin
      dec = DEC_LAST_RUN;
    end else if ((cfg_i.frequency == FREQ_HOURLY) && front_i.eq_stop &&
                 (front_i.hour == cfg_i.stop_hour)) begin
      dec = DEC_LAST_RUN;
    end else if (cfg_i.frequency == FREQ_ONCE) begin
      dec = DEC_LAST_RUN;
    end else begin
      dec = DEC_RUN;
    end
  end

  // day candidates with month wrap
  assign daily_day   = (front_i.day_p1 > {1'b0, front_i.mlen}) ? 5'd1 : front_i.day_p1[4:0];
  assign wk_day      = (front_i.day_wk > {1'b0, front_i.mlen}) ?
                       5'(front_i.day_wk - {1'b0, front_i.mlen}) : front_i.day_wk[4:0];
  assign weekly_day  = (front_i.day_p7 > {1'b0, front_i.mlen}) ?
                       5'(front_i.day_p7 - {1'b0, front_i.mlen}) : front_i.day_p7[4:0];
  assign monthly_day = (front_i.day > front_i.nlen) ? front_i.nlen : front_i.day;

  // hourly: next hour, or the start hour once the stop slot is reached (next day unless start is later than stop)
  always_comb begin
    hr_day  = front_i.day;
    hr_hour = cfg_i.start_hour;
    if ((front_i.hour != cfg_i.stop_hour) || (cfg_i.start_hour == cfg_i.stop_hour)) begin
      hr_hour = front_i.hour_p1[4:0];
      if (front_i.hour_p1 > LAST_HOUR) begin
        hr_hour = 5'd0;
        hr_day  = daily_day;
      end
    end else if (cfg_i.start_hour < cfg_i.stop_hour) begin
      hr_day = daily_day;
    end
  end

  assign freq_ok = (cfg_i.frequency >= FREQ_DAILY) && (cfg_i.frequency <= FREQ_MONTHLY);

  // result assembly
  always_comb begin
    res_d.start_match  = front_i.match;
    res_d.decision     = dec;
    res_d.alarm_valid  = 1'b0;
    res_d.alarm_day    = 5'd0;
    res_d.alarm_hour   = 5'd0;
    res_d.alarm_minute = 6'd0;
    if ((dec != DEC_EXPIRED) && (dec != DEC_LAST_RUN) && freq_ok) begin
      res_d.alarm_valid  = 1'b1;
      res_d.alarm_minute = cfg_i.start_minute;
      res_d.alarm_hour   = cfg_i.start_hour;
      case (cfg_i.frequency)
        FREQ_DAILY:    res_d.alarm_day = daily_day;
        FREQ_HOURLY: begin
          res_d.alarm_day  = hr_day;
          res_d.alarm_hour = hr_hour;
        end
        FREQ_WEEKDAYS: res_d.alarm_day = wk_day;
        FREQ_WEEKLY:   res_d.alarm_day = weekly_day;
        default:       res_d.alarm_day = monthly_day;
      endcase
    end
    // saturate at zero when the elapsed seconds exceed the on time
    res_d.power_off_ticks = (front_i.on_ticks > 18'(front_i.off_ticks)) ?
                            front_i.on_ticks - 18'(front_i.off_ticks) : 18'd0;
  end

  // output register
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

  // an armed alarm never comes with an expired or last-run decision
  a_alarm_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && res_q.alarm_valid) |->
      ((res_q.decision != DEC_EXPIRED) && (res_q.decision != DEC_LAST_RUN)))
    else $error("alarm armed for an expired or last-run item");

  // alarm fields are zero when no alarm is armed
  a_alarm_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !res_q.alarm_valid) |->
      ((res_q.alarm_day == 5'd0) && (res_q.alarm_hour == 5'd0) &&
       (res_q.alarm_minute == 6'd0)))
    else $error("alarm fields set without an alarm");

  // a slot match needs the timer enabled
  a_match_en: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && res_q.start_match) |-> cfg_i.timer_enabled)
    else $error("start match while timer disabled");

  // one result per item that left the front stage
  a_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $past(valid_i))
    else $error("result strobe without an item");

endmodule

FILE: rtl/core/recurring_wake_alarm_scheduler.sv
// ----------------------------------------------------------------------------
// recurring_wake_alarm_scheduler
// Judges calendar time stamps against a recurring timer set-up and returns
// the start match, the run decision, the next wake alarm and power-off ticks.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                   payload
//  item      in         start & !busy               item_i   (rwas_item_t)
//  result    out        done_o, one cycle, no stall result_o (rwas_result_t)
//  config    in         cfg_we_i                    cfg_idx_i, cfg_wdata_i
//
//  An item can enter every cycle; busy is always low.
//  The path runs through the input register, the front stage and the back stage.
//  The result is on result_o for the single cycle that done_o is high.
//  Reset clears the valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module recurring_wake_alarm_scheduler import rwas_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  input  rwas_item_t   item_i,
  output logic         done_o,
  output rwas_result_t result_o,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [15:0]  cfg_wdata_i
);

  rwas_cfg_t   cfg;
  rwas_item_t  item_q;
  logic        in_valid_q;
  logic        front_valid;
  rwas_front_t front;

  // the pipeline never stalls
  assign busy = 1'b0;

  // configuration registers
  rwas_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // input register
  always_ff @(posedge clk_i) begin
    item_q <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
    end
  end

  rwas_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (in_valid_q),
    .item_i  (item_q),
    .valid_o (front_valid),
    .front_o (front)
  );

  rwas_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .valid_i  (front_valid),
    .front_i  (front),
    .valid_o  (done_o),
    .result_o (result_o)
  );

endmodule
